>>> hw/rtl/carmichael_lambda_unit_defines.svh
// Assertion macros for the Carmichael lambda unit.
`ifndef CARMICHAEL_LAMBDA_UNIT_DEFINES_SVH
`define CARMICHAEL_LAMBDA_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CLU_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
`define CLU_ASSERT_RST(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define CLU_ASSERT(label, clk_s, rst_s, prop, msg)
`define CLU_ASSERT_RST(label, clk_s, prop, msg)
`endif
`endif

>>> hw/rtl/clu_pkg.sv
`timescale 1ns / 1ps
package clu_pkg;
  localparam int NUM_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic div_start;
    logic acc_div;
    logic set_fac;
    logic set_tail;
    logic mul_fac;
    logic step_d;
    logic gcd_init;
    logic gcd_start;
    logic gcd_swap;
    logic ldiv_start;
    logic mul_acc;
    logic cap;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic rem_zero;
    logic d_sq_gt;
    logic rest_gt1;
    logic gb_zero;
    logic mul_busy;
    logic k_zero;
  } sts_t;
endpackage

>>> hw/rtl/clu_datapath.sv
`timescale 1ns / 1ps
module clu_datapath #(
  parameter int NUM_WIDTH = clu_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NUM_WIDTH-1:0] n_in,
  input  clu_pkg::cmd_t        cmd,
  output clu_pkg::sts_t        sts,
  output logic [31:0]          res_out
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0]   rest, d, fac, acc, ga, gb;
  logic [CW-1:0]          cnt_k;
  logic [NUM_WIDTH-1:0]   quo, dvs, rem_r;
  logic [CW-1:0]          dcnt;
  logic                   div_busy;
  logic [NUM_WIDTH-1:0]   mul_a, mul_b, mul_p, mul_p_next;
  logic [CW-1:0]          mcnt;
  logic                   mul_busy, mul_to_acc;
  logic [NUM_WIDTH:0]     trial;
  logic [2*NUM_WIDTH-1:0] d_wide, dsq;
  logic [31:0]            res;

  assign trial = {rem_r, quo[NUM_WIDTH-1]} - {1'b0, dvs};
  assign d_wide = {{NUM_WIDTH{1'b0}}, d};
  assign dsq = d_wide * d_wide;

  // Every partial product is at most the final product, which divides the final lambda, so NUM_WIDTH bits hold it.
  assign mul_p_next = (mul_p << 1) + (mul_b[NUM_WIDTH-1] ? mul_a : '0);

  // Shift-subtract divider: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      dcnt     <= '0;
    end else if (cmd.div_start || cmd.gcd_start || cmd.ldiv_start) begin
      div_busy <= 1'b1;
      dcnt     <= CW'(NUM_WIDTH);
      rem_r    <= '0;
      if (cmd.div_start) begin
        quo <= rest;
        dvs <= d;
      end else if (cmd.gcd_start) begin
        quo <= ga;
        dvs <= gb;
      end else begin
        quo <= acc;
        dvs <= ga;
      end
    end else if (div_busy) begin
      if (!trial[NUM_WIDTH]) begin
        rem_r <= trial[NUM_WIDTH-1:0];
        quo   <= {quo[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[NUM_WIDTH-2:0], quo[NUM_WIDTH-1]};
        quo   <= {quo[NUM_WIDTH-2:0], 1'b0};
      end
      dcnt <= dcnt - CW'(1);
      if (dcnt == CW'(1)) div_busy <= 1'b0;
    end
  end

  // Shift-add multiplier, one bit of mul_b per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mcnt     <= '0;
    end else if (cmd.mul_fac || cmd.mul_acc) begin
      mul_busy   <= 1'b1;
      mcnt       <= CW'(NUM_WIDTH);
      mul_p      <= '0;
      mul_to_acc <= cmd.mul_acc;
      mul_a      <= cmd.mul_acc ? quo : fac;
      mul_b      <= cmd.mul_acc ? fac : d;
    end else if (mul_busy) begin
      mul_p <= mul_p_next;
      mul_b <= mul_b << 1;
      mcnt  <= mcnt - CW'(1);
      if (mcnt == CW'(1)) mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest  <= n_in;
      d     <= NUM_WIDTH'(2);
      acc   <= NUM_WIDTH'(1);
      cnt_k <= '0;
    end
    if (cmd.acc_div) begin
      rest  <= quo;
      cnt_k <= cnt_k + CW'(1);
    end
    if (cmd.set_fac) begin
      // Powers of two come from a short table; an odd prime starts at p-1 and
      // is multiplied by p once for each remaining power.
      if (d == NUM_WIDTH'(2)) begin
        fac <= (cnt_k == CW'(1)) ? NUM_WIDTH'(1)
             : (cnt_k == CW'(2)) ? NUM_WIDTH'(2)
             : (NUM_WIDTH'(1) << (cnt_k - CW'(2)));
        cnt_k <= '0;
      end else begin
        fac   <= d - NUM_WIDTH'(1);
        cnt_k <= cnt_k - CW'(1);
      end
    end
    if (cmd.set_tail) fac <= rest - NUM_WIDTH'(1);
    if (cmd.mul_fac) cnt_k <= cnt_k - CW'(1);
    if (cmd.step_d) begin
      d     <= d + NUM_WIDTH'(1);
      cnt_k <= '0;
    end
    if (cmd.gcd_init) begin
      ga <= acc;
      gb <= fac;
    end
    if (cmd.gcd_swap) begin
      ga <= gb;
      gb <= rem_r;
    end
    if (mul_busy && mcnt == CW'(1)) begin
      if (mul_to_acc) acc <= mul_p_next;
      else fac <= mul_p_next;
    end
    if (cmd.cap) res <= 32'(acc);
  end

  assign sts.div_busy = div_busy;
  assign sts.rem_zero = (rem_r == '0);
  assign sts.d_sq_gt  = dsq > {{NUM_WIDTH{1'b0}}, rest};
  assign sts.rest_gt1 = rest > NUM_WIDTH'(1);
  assign sts.gb_zero  = (gb == '0);
  assign sts.mul_busy = mul_busy;
  assign sts.k_zero   = (cnt_k == '0);
  assign res_out = res;
endmodule

>>> hw/rtl/clu_ctrl.sv
`timescale 1ns / 1ps
module clu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          zero_in,
  input  logic          out_stall,
  input  clu_pkg::sts_t sts,
  output clu_pkg::cmd_t cmd,
  output logic          in_stall,
  output logic          out_valid,
  output logic          out_inv
);
  localparam logic [3:0] S_IDLE = 4'd0, S_TEST = 4'd1, S_DIVW = 4'd2,
    S_DIVC = 4'd3, S_REDIV = 4'd4, S_POWM = 4'd5, S_POWW = 4'd6,
    S_GSTART = 4'd7, S_GWAIT = 4'd8, S_LWAIT = 4'd9, S_LDIV = 4'd10,
    S_MWAIT = 4'd11, S_TAIL = 4'd12, S_DONE = 4'd13;

  logic [3:0] state, state_next;
  logic       tail, tail_next, inv_cur, inv_cur_next;
  logic       out_full, out_full_next, out_inv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tail     <= 1'b0;
      inv_cur  <= 1'b0;
      out_full <= 1'b0;
      out_inv  <= 1'b0;
    end else begin
      state    <= state_next;
      tail     <= tail_next;
      inv_cur  <= inv_cur_next;
      out_full <= out_full_next;
      out_inv  <= out_inv_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    tail_next = tail;
    inv_cur_next = inv_cur;
    out_inv_next = out_inv;
    out_full_next = out_full && out_stall;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        tail_next = 1'b0;
        inv_cur_next = zero_in;
        state_next = zero_in ? S_DONE : S_TEST;
      end
      S_TEST: begin
        if (sts.d_sq_gt) begin
          state_next = sts.rest_gt1 ? S_TAIL : S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIVW;
        end
      end
      S_DIVW: if (!sts.div_busy) state_next = S_DIVC;
      S_DIVC: begin
        if (sts.rem_zero) begin
          // Keep dividing by the same divisor, whatever the new cofactor is.
          cmd.acc_div = 1'b1;
          state_next = S_REDIV;
        end else if (!sts.k_zero) begin
          cmd.set_fac = 1'b1;
          state_next = S_POWM;
        end else begin
          cmd.step_d = 1'b1;
          state_next = S_TEST;
        end
      end
      S_REDIV: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVW;
      end
      S_POWM: begin
        if (sts.k_zero) begin
          cmd.gcd_init = 1'b1;
          state_next = S_GWAIT;
        end else begin
          cmd.mul_fac = 1'b1;
          state_next = S_POWW;
        end
      end
      S_POWW: if (!sts.mul_busy) state_next = S_POWM;
      S_TAIL: begin
        // The leftover cofactor is a prime of power one.
        tail_next = 1'b1;
        cmd.set_tail = 1'b1;
        state_next = S_GSTART;
      end
      S_GSTART: begin
        cmd.gcd_init = 1'b1;
        state_next = S_GWAIT;
      end
      S_GWAIT: begin
        if (sts.gb_zero) begin
          cmd.ldiv_start = 1'b1;
          state_next = S_LDIV;
        end else begin
          cmd.gcd_start = 1'b1;
          state_next = S_LWAIT;
        end
      end
      S_LWAIT: if (!sts.div_busy) begin
        cmd.gcd_swap = 1'b1;
        state_next = S_GWAIT;
      end
      S_LDIV: if (!sts.div_busy) begin
        cmd.mul_acc = 1'b1;
        state_next = S_MWAIT;
      end
      S_MWAIT: if (!sts.mul_busy) begin
        if (tail) begin
          state_next = S_DONE;
        end else begin
          cmd.step_d = 1'b1;
          state_next = S_TEST;
        end
      end
      S_DONE: if (!out_full || !out_stall) begin
        cmd.cap = 1'b1;
        out_full_next = 1'b1;
        out_inv_next = inv_cur;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/carmichael_lambda_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake                   | Payload
// input    | n_valid / n_stall           | n_value
// result   | lambda_valid / lambda_stall | lambda_value, invalid
// One item is worked on at a time. Each trial divisor goes through a test, a serial
// divide and a check; each prime power found adds serial passes for its power, gcd and lcm.
// Reset returns the controller to idle and empties the result register.
// A finished result waits in its output register while the next item is taken;
// that item stalls at its end until the register has been read.
`include "carmichael_lambda_unit_defines.svh"
module carmichael_lambda_unit #(
  parameter int NUM_WIDTH = clu_pkg::NUM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        n_valid,
  output logic        n_stall,
  input  logic [31:0] n_value,
  output logic        lambda_valid,
  input  logic        lambda_stall,
  output logic [31:0] lambda_value,
  output logic        invalid
);
  clu_pkg::cmd_t cmd;
  clu_pkg::sts_t sts;
  logic [31:0] res;
  logic        inv;
  logic [NUM_WIDTH-1:0] n_cut;

  assign n_cut = n_value[NUM_WIDTH-1:0];

  clu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(n_valid), .zero_in(n_cut == '0),
    .out_stall(lambda_stall), .sts(sts), .cmd(cmd), .in_stall(n_stall),
    .out_valid(lambda_valid), .out_inv(inv)
  );

  clu_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .n_in(n_cut), .cmd(cmd), .sts(sts), .res_out(res)
  );

  assign invalid = inv;
  assign lambda_value = inv ? 32'd0 : res;

  `CLU_ASSERT(a_hold, clk, rst, (lambda_valid && lambda_stall) |=> lambda_valid, "result dropped")
  `CLU_ASSERT(a_stable, clk, rst, (lambda_valid && lambda_stall) |=> ($stable(lambda_value) && $stable(invalid)), "stalled result changed")
  `CLU_ASSERT_RST(a_rst_empty, clk, rst |=> !lambda_valid, "result present after reset")
endmodule
